@@ hdl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/lkpm_pkg.sv @@
`timescale 1ns / 1ps

package lkpm_pkg;

   localparam int KEY_LEN_CHARS = 32;
   localparam int KEY_REG_COUNT = 4;
   localparam int COL_W         = 6;
   localparam int CSR_IDX_W     = 3;

   localparam logic [COL_W-1:0] KEY_LEN = 6'd32;
   localparam logic [COL_W-1:0] COL_SAT = 6'd33;

   localparam logic [7:0] SEP_CHAR = 8'h7C;
   localparam logic [7:0] NL_CHAR  = 8'h0A;
   localparam logic [7:0] NUL_CHAR = 8'h00;

   // key register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_0_7   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_8_15  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_16_23 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_24_31 = 3'd3;

   typedef logic [KEY_LEN_CHARS-1:0][7:0] lkpm_key_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } lkpm_req_type;

   typedef struct packed {
      logic        found;
      logic [19:0] line_offset;
      logic [20:0] line_length;
   } lkpm_rsp_type;

   // scan core to output stage
   typedef struct packed {
      logic         valid;
      lkpm_rsp_type rsp;
   } lkpm_result_type;

endpackage

@@ hdl/lkpm_key_store.sv @@
`timescale 1ns / 1ps

module lkpm_key_store import lkpm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data,
   output lkpm_key_type         key_chars
);

   logic [KEY_REG_COUNT-1:0][63:0] key_ff;
   logic [KEY_REG_COUNT-1:0][63:0] key_in;

   always_comb begin
      key_in = key_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEY_0_7:   key_in[0] = csr_data;
            CSR_KEY_8_15:  key_in[1] = csr_data;
            CSR_KEY_16_23: key_in[2] = csr_data;
            CSR_KEY_24_31: key_in[3] = csr_data;
            default:       key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // character 8r+i sits in byte 7-i of register r, msb first
   always_comb begin
      for (int r = 0; r < KEY_REG_COUNT; r++) begin
         for (int i = 0; i < 8; i++) begin
            key_chars[8*r+i] = key_ff[r][63-8*i -: 8];
         end
      end
   end

endmodule

@@ hdl/lkpm_scan.sv @@
`timescale 1ns / 1ps

module lkpm_scan import lkpm_pkg::*; #(
   parameter int DB_MAX_BYTES = 1048576
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  lkpm_req_type    item,
   input  lkpm_key_type    key_chars,
   output lkpm_result_type result
);

   localparam int OFS_W = $clog2(DB_MAX_BYTES);
   localparam int LEN_W = OFS_W + 1;
   localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(DB_MAX_BYTES - 1);

   logic             done_ff, done_in;
   logic [COL_W-1:0] column_ff, column_in;
   logic             mismatch_ff, mismatch_in;
   logic [OFS_W-1:0] offset_ff, offset_in;
   logic [OFS_W-1:0] start_ff, start_in;

   // state as seen after a possible restart
   logic             cur_done;
   logic [COL_W-1:0] cur_col;
   logic             cur_mis;
   logic [OFS_W-1:0] cur_ofs;
   logic [OFS_W-1:0] cur_start;
   logic             is_last;
   logic             is_term;
   logic             char_bad;
   logic [COL_W-1:0] col_inc;
   logic             mis_inc;
   logic             emit;
   logic             hit;
   logic [LEN_W-1:0] len;

   always_comb begin
      cur_done  = item.first_byte ? 1'b0 : done_ff;
      cur_col   = item.first_byte ? '0 : column_ff;
      cur_mis   = item.first_byte ? 1'b0 : mismatch_ff;
      cur_ofs   = item.first_byte ? '0 : offset_ff;
      cur_start = item.first_byte ? '0 : start_ff;

      is_last = item.last_byte || (cur_ofs >= OFS_LAST);
      is_term = (item.data_byte == NL_CHAR) || (item.data_byte == NUL_CHAR);

      if (cur_col < KEY_LEN) begin
         char_bad = item.data_byte != key_chars[cur_col[4:0]];
      end else if (cur_col == KEY_LEN) begin
         char_bad = item.data_byte != SEP_CHAR;
      end else begin
         char_bad = 1'b0;
      end
      col_inc = (cur_col < COL_SAT) ? cur_col + COL_W'(1) : cur_col;
      mis_inc = cur_mis || char_bad;

      done_in     = cur_done;
      column_in   = cur_col;
      mismatch_in = cur_mis;
      offset_in   = cur_ofs;
      start_in    = cur_start;
      emit        = 1'b0;
      hit         = 1'b0;
      len         = '0;

      if (!cur_done) begin
         if (!is_term) begin
            column_in   = col_inc;
            mismatch_in = mis_inc;
            if (is_last) begin
               emit = 1'b1;
               hit  = (col_inc >= COL_SAT) && !mis_inc;
               len  = (LEN_W'(cur_ofs) + LEN_W'(1)) - LEN_W'(cur_start);
            end else begin
               offset_in = cur_ofs + OFS_W'(1);
            end
         end else begin
            len = LEN_W'(cur_ofs) - LEN_W'(cur_start);
            if ((cur_col >= COL_SAT) && !cur_mis) begin
               emit = 1'b1;
               hit  = 1'b1;
            end else if (((item.data_byte == NUL_CHAR) && (cur_col < COL_SAT)) || is_last) begin
               emit = 1'b1;
            end else begin
               start_in    = cur_ofs + OFS_W'(1);
               column_in   = '0;
               mismatch_in = 1'b0;
               offset_in   = cur_ofs + OFS_W'(1);
            end
         end
         if (emit) begin
            done_in = 1'b1;
         end
      end

      result.valid           = step && emit;
      result.rsp.found       = hit;
      result.rsp.line_offset = hit ? 20'(cur_start) : '0;
      result.rsp.line_length = hit ? 21'(len) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff     <= 1'b1;
         column_ff   <= '0;
         mismatch_ff <= 1'b0;
         offset_ff   <= '0;
         start_ff    <= '0;
      end else if (step) begin
         done_ff     <= done_in;
         column_ff   <= column_in;
         mismatch_ff <= mismatch_in;
         offset_ff   <= offset_in;
         start_ff    <= start_in;
      end
   end

endmodule

@@ hdl/line_key_prefix_matcher.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// line_key_prefix_matcher: streams a text database one byte per request and
// reports the first line whose first 32 characters equal the key held in the
// four 64-bit key registers and whose 33rd character is '|'.
// channels: req_* carries one database byte with first/last marks, rsp_*
// carries one result per search (found, line offset, line length), csr_*
// writes the key registers and is always ready.
// path: an accepted request waits in the input register, the scan core
// processes it, and a result that ends the search goes to the result register.
// throughput: one byte per cycle while no result waits under rsp_stall; the
// scan core compares each byte and updates its counters combinationally.
// reset: key registers clear, the block idles and ignores bytes until one
// marked first_byte arrives.
// stall: a waiting result holds in the output register; if empty, the input
// register takes one more request, then req_stall rises until the result goes.
// users must write the key only while no search is in flight; not enforced.
module line_key_prefix_matcher import lkpm_pkg::*; #(
   parameter int DB_MAX_BYTES = 1048576
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lkpm_req_type         req_payload,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lkpm_rsp_type         rsp_payload,
   // key register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);

   // input register
   logic         in_valid_ff, in_valid_in;
   lkpm_req_type in_item_ff;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   lkpm_rsp_type rsp_ff;

   lkpm_key_type    key_chars;
   lkpm_result_type result;
   logic            proc_fire;
   logic            req_accept;

   assign csr_ready = 1'b1;

   lkpm_key_store u_key_store (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .key_chars (key_chars)
   );

   // the held request moves on once the result register has room
   assign proc_fire  = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !proc_fire;
   assign req_accept = req_valid && !req_stall;

   lkpm_scan #(
      .DB_MAX_BYTES (DB_MAX_BYTES)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (proc_fire),
      .item      (in_item_ff),
      .key_chars (key_chars),
      .result    (result)
   );

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (proc_fire) begin
         rsp_valid_in = result.valid;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_payload;
      end
      if (proc_fire && result.valid) begin
         rsp_ff <= result.rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a miss reports zero offset and length
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_valid && !rsp_payload.found, (rsp_payload.line_offset == '0) && (rsp_payload.line_length == '0))
   // an empty result register never holds back a request
   `ASSERT_IMPLIES(a_no_false_stall, clock, reset, !rsp_valid_ff, !req_stall)
   // a result only appears from a processed request
   `ASSERT_NEXT(a_rsp_from_fire, clock, reset, (!rsp_valid_ff || !rsp_stall) && !proc_fire, !rsp_valid_ff)

endmodule
